>>> sv/pmmu_pkg.sv
`default_nettype none
package pmmu_pkg;
    localparam int NUM_FRAMES_D = 16;
    localparam int NUM_PAGES_D  = 256;
    localparam int NUM_PROCS_D  = 4;
    localparam int PID_W   = 2;
    localparam int VA_W    = 16;
    localparam int PAGE_W  = 8;
    localparam int PA_W    = 12;
    localparam int POL_W   = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    typedef enum logic [1:0] {
        POL_ZERO  = 2'd0,
        POL_FIFO  = 2'd1,
        POL_LRU   = 2'd2,
        POL_CLOCK = 2'd3
    } t_policy;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_LOOK,
        ST_VICT,
        ST_VWB,
        ST_LRU,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

>>> sv/pmmu_lru.sv
`default_nettype none
// recency list kept in a small memory; one entry moved at a time, each by a read and a shift step
module pmmu_lru #(
    parameter int NUM_FRAMES = pmmu_pkg::NUM_FRAMES_D,
    parameter int FW = $clog2(NUM_FRAMES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_remove,
    input  wire logic [FW-1:0] i_frame,
    output logic               o_busy,
    output logic               o_tail_ok,
    output logic [FW-1:0]      o_tail
);
    import pmmu_pkg::*;
    localparam int LW = $clog2(NUM_FRAMES + 1);

    logic [FW-1:0] r_mem [NUM_FRAMES];
    logic [FW-1:0] r_tail;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_pos;
    logic [FW-1:0] r_frame;
    logic [1:0]    r_ph;   // 0 idle, 1 read, 2 shift
    logic [FW-1:0] r_rd;

    // list order: index 0 most recent. shift phase walks from limit down to 1,
    // moving each element one place up, then writes frame at 0
    logic [LW-1:0] w_lim;
    logic [LW-1:0] w_hitpos;
    logic          w_found;
    always_comb begin
        w_found  = 1'b0;
        w_hitpos = '0;
        for (int k = 0; k < NUM_FRAMES; k++) begin
            if (!w_found && (LW'(k) < r_len) && r_mem[k] == i_frame) begin
                w_found  = 1'b1;
                w_hitpos = LW'(k);
            end
        end
        if (i_remove && w_found)
            w_lim = w_hitpos;
        else if (r_len >= LW'(NUM_FRAMES))
            w_lim = LW'(NUM_FRAMES - 1);
        else
            w_lim = r_len;
    end

    logic [LW-1:0] n_len;
    always_comb begin
        if (i_remove && w_found)
            n_len = r_len;
        else if (r_len >= LW'(NUM_FRAMES))
            n_len = LW'(NUM_FRAMES);
        else
            n_len = r_len + LW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ph  <= 2'd0;
        end else begin
            unique case (r_ph)
                2'd0: begin
                    if (i_start) begin
                        r_frame <= i_frame;
                        r_pos   <= w_lim;
                        r_len   <= n_len;
                        r_ph    <= 2'd1;
                    end
                end
                2'd1: begin
                    if (r_pos == '0) begin
                        r_mem[0] <= r_frame;
                        r_ph     <= 2'd0;
                    end else begin
                        r_rd <= r_mem[FW'(r_pos - LW'(1))];
                        r_ph <= 2'd2;
                    end
                end
                default: begin
                    r_mem[FW'(r_pos)] <= r_rd;
                    r_pos <= r_pos - LW'(1);
                    r_ph  <= 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= r_mem[FW'(r_len - LW'(1))];
    end

    assign o_busy    = (r_ph != 2'd0) || i_start;
    assign o_tail_ok = (r_len != '0);
    assign o_tail    = r_tail;
endmodule
`default_nettype wire

>>> sv/paged_mmu_with_replacement_unit.sv
`default_nettype none
// Paged MMU: one access per transfer on s_axis (pid, virtual address, write
// flag); one result per access on m_axis. The page table (valid, dirty and
// frame per pid and page) and the frame owner table sit in synchronous
// memories. After reset the page table is cleared one entry per cycle, which
// holds s_axis_tready low until all 2**(pid bits + page bits) entries, 1024 by
// default, are cleared. An access goes through lookup, list update and output
// on a hit or a free-frame miss, with an owner read and a victim entry read
// added on a miss that evicts, and from lookup straight to output on a range
// error. Under the lru policy the list update starts a reorder of the recency
// list, one list entry at a time by a read and a shift step, and no new access
// is taken until it is done. A result waiting on m_axis does not hold off the
// next access, but holds it in its output step. policy may be written only while idle.
module paged_mmu_with_replacement_unit #(
    parameter int NUM_FRAMES = pmmu_pkg::NUM_FRAMES_D,
    parameter int NUM_PAGES  = pmmu_pkg::NUM_PAGES_D,
    parameter int NUM_PROCS  = pmmu_pkg::NUM_PROCS_D
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pmmu_pkg::POL_W-1:0]     i_cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // pid[1:0], virt_addr[17:2], is_write[18], zero fill
    input  wire logic [pmmu_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // phys_addr[11:0], hit[12], range_error[13], evicted[14],
    // evict_pid[16:15], evict_page[24:17], writeback[25], zero fill
    output logic [pmmu_pkg::OUT_W-1:0]          m_axis_tdata
);
    import pmmu_pkg::*;
    localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PGW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int PRW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int IW  = PRW + PGW;
    localparam int UW  = $clog2(NUM_FRAMES + 1);
    localparam int DEPTH = 1 << IW;

    t_state r_st, n_st;
    logic [POL_W-1:0] r_pol;

    logic [PID_W-1:0]  r_pid;
    logic [PAGE_W-1:0] r_page, r_off;
    logic              r_wr;
    logic              r_err;
    logic [FW-1:0]     r_frame;
    logic              r_hit, r_ev, r_wb;
    logic [PID_W-1:0]  r_epid;
    logic [PAGE_W-1:0] r_epage;
    logic [UW-1:0]     r_used;
    logic [FW-1:0]     r_fifo;
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;
    logic [IW-1:0]     r_clr;

    // page table entry: valid, dirty, frame
    logic [FW+1:0] r_pt [DEPTH];
    logic [FW+1:0] r_pt_rd;
    logic [IW-1:0] r_pt_ra;
    logic [PID_W+PAGE_W-1:0] r_own [NUM_FRAMES];
    logic [PID_W+PAGE_W-1:0] r_own_rd;

    logic [IW-1:0] w_idx;
    assign w_idx = {r_pid[PRW-1:0], r_page[PGW-1:0]};

    logic w_pt_valid;
    assign w_pt_valid = r_pt_rd[FW+1];

    logic          lru_start, lru_remove, lru_busy, lru_tail_ok;
    logic [FW-1:0] lru_frame, lru_tail;

    pmmu_lru #(.NUM_FRAMES(NUM_FRAMES), .FW(FW)) u_lru (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lru_start),
        .i_remove(lru_remove), .i_frame(lru_frame), .o_busy(lru_busy),
        .o_tail_ok(lru_tail_ok), .o_tail(lru_tail)
    );

    assign s_axis_tready = (r_st == ST_IDLE) && !lru_busy;
    logic w_acc;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // output register free or being emptied this cycle
    logic w_out_go;
    assign w_out_go = !r_ovalid || m_axis_tready;

    logic w_full;
    assign w_full = (r_used >= UW'(NUM_FRAMES));

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLR:  if (r_clr == '1) n_st = ST_IDLE;
            ST_IDLE: if (w_acc) n_st = ST_LOOK;
            ST_LOOK: begin
                if (r_err) n_st = ST_OUT;
                else if (w_pt_valid || !w_full) n_st = ST_LRU;
                else n_st = ST_VICT;
            end
            ST_VICT: n_st = ST_VWB;
            ST_VWB:  n_st = ST_LRU;
            ST_LRU:  n_st = ST_OUT;
            ST_OUT:  if (w_out_go) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // victim frame choice
    logic [FW-1:0] w_vf;
    always_comb begin
        if (r_pol == POL_FIFO) w_vf = r_fifo;
        else if (r_pol == POL_LRU && lru_tail_ok) w_vf = lru_tail;
        else w_vf = '0;
    end

    always_comb begin
        lru_start  = 1'b0;
        lru_remove = 1'b0;
        lru_frame  = r_frame;
        if (r_st == ST_LRU && r_pol == POL_LRU) begin
            if (r_hit) begin
                lru_start  = 1'b1;
                lru_remove = 1'b1;
            end else if (!r_ev || lru_tail_ok) begin
                // victim rotation: removing the tail then pushing on an eviction; a free-frame miss only pushes
                lru_start  = 1'b1;
                lru_remove = r_ev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_CLR;
            r_clr    <= '0;
            r_pol    <= POL_FIFO;
            r_used   <= '0;
            r_fifo   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_pol <= i_cfg_wdata;
            if (r_st == ST_OUT && w_out_go) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                ST_CLR: begin
                    r_pt[r_clr] <= '0;
                    r_clr       <= r_clr + IW'(1);
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        r_pid  <= s_axis_tdata[1:0];
                        r_page <= s_axis_tdata[17:10];
                        r_off  <= s_axis_tdata[9:2];
                        r_wr   <= s_axis_tdata[18];
                        r_err  <= (32'(s_axis_tdata[17:10]) >= 32'(NUM_PAGES)) ||
                                  (32'(s_axis_tdata[1:0]) >= 32'(NUM_PROCS));
                    end
                end
                ST_LOOK: begin
                    r_hit <= 1'b0; r_ev <= 1'b0; r_wb <= 1'b0;
                    r_epid <= '0; r_epage <= '0;
                    if (!r_err) begin
                        if (w_pt_valid) begin
                            r_hit   <= 1'b1;
                            r_frame <= r_pt_rd[FW-1:0];
                            if (r_wr) r_pt[w_idx] <= {2'b11, r_pt_rd[FW-1:0]};
                        end else if (!w_full) begin
                            r_frame <= FW'(r_used);
                            r_used  <= r_used + UW'(1);
                            r_pt[w_idx] <= {1'b1, r_wr, FW'(r_used)};
                            r_own[FW'(r_used)] <= {r_page, r_pid};
                        end else begin
                            r_frame <= w_vf;
                            r_ev    <= 1'b1;
                            if (r_pol == POL_FIFO)
                                r_fifo <= (32'(r_fifo) + 1 >= NUM_FRAMES) ? '0
                                          : r_fifo + FW'(1);
                        end
                    end
                end
                ST_VICT: begin
                    r_epid  <= r_own_rd[PID_W-1:0];
                    r_epage <= r_own_rd[PID_W +: PAGE_W];
                    r_pt[w_idx] <= {1'b1, r_wr, r_frame};
                end
                ST_VWB: begin
                    r_wb <= r_pt_rd[FW+1] & r_pt_rd[FW];
                    r_pt[r_pt_ra]  <= '0;
                    r_own[r_frame] <= {r_page, r_pid};
                end
                ST_OUT: begin
                    if (w_out_go) begin
                        if (r_err)
                            r_odata <= OUT_W'({1'b1, 13'd0});
                        else
                            r_odata <= OUT_W'({r_wb, r_epage, r_epid, r_ev, 1'b0,
                                       r_hit, PA_W'({r_frame, r_off})});
                    end
                end
                default: ;
            endcase
        end
    end

    // memory read ports
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE) begin
            r_pt_ra <= {s_axis_tdata[PRW-1:0], s_axis_tdata[10 +: PGW]};
            r_pt_rd <= r_pt[{s_axis_tdata[PRW-1:0], s_axis_tdata[10 +: PGW]}];
        end else if (r_st == ST_VICT) begin
            r_pt_ra <= {r_own_rd[PRW-1:0], r_own_rd[PID_W +: PGW]};
            r_pt_rd <= r_pt[{r_own_rd[PRW-1:0], r_own_rd[PID_W +: PGW]}];
        end
        r_own_rd <= r_own[(r_st == ST_LOOK) ? w_vf : r_frame];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire

>>> tb/sv/paged_mmu_with_replacement_unit_test.sv
`timescale 1ns / 1ps
module paged_mmu_with_replacement_unit_test;
    import pmmu_pkg::*;

    localparam int NFR = NUM_FRAMES_D;
    localparam int NPG = NUM_PAGES_D;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 2 * NFR + 16;

    typedef struct packed {
        logic             writeback;
        logic [PAGE_W-1:0] evict_page;
        logic [PID_W-1:0]  evict_pid;
        logic             evicted;
        logic             range_error;
        logic             hit;
        logic [PA_W-1:0]   phys_addr;
    } xlat_t;

    typedef struct {
        logic [PID_W-1:0] pid;
        logic [VA_W-1:0]  va;
        logic             wr;
        bit               typed;
        xlat_t            res;
    } access_row_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [POL_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    paged_mmu_with_replacement_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // translation model state
    bit        pt_valid [NUM_PROCS_D*NPG];
    bit        pt_dirty [NUM_PROCS_D*NPG];
    int        pt_frame [NUM_PROCS_D*NPG];
    int        own_pid  [NFR];
    int        own_page [NFR];
    int        frames_handed;
    int        fifo_next;
    int        recency [NFR];
    int        recency_len;
    t_policy   cur_policy;

    xlat_t     pending_xlat [$];
    int        errors;
    int        idle_cycles;

    function automatic void recency_drop(int f);
        for (int i = 0; i < recency_len; i++) begin
            if (recency[i] == f) begin
                for (int j = i; j + 1 < recency_len; j++) recency[j] = recency[j+1];
                recency_len--;
                return;
            end
        end
    endfunction

    function automatic void recency_front(int f);
        if (recency_len >= NFR) recency_len = NFR - 1;
        for (int j = recency_len; j > 0; j--) recency[j] = recency[j-1];
        recency[0] = f;
        recency_len++;
    endfunction

    function automatic xlat_t translate(logic [PID_W-1:0] pid, logic [VA_W-1:0] va, logic wr);
        xlat_t r;
        int pg;
        int idx;
        int f;
        int vidx;
        r = '0;
        pg = int'(va[15:8]);
        idx = int'(pid) * NPG + pg;
        if (pt_valid[idx]) begin
            r.hit = 1'b1;
            f = pt_frame[idx];
            if (wr) pt_dirty[idx] = 1'b1;
            if (cur_policy == POL_LRU) begin
                recency_drop(f);
                recency_front(f);
            end
        end else begin
            if (frames_handed < NFR) begin
                f = frames_handed;
                frames_handed++;
                if (cur_policy == POL_LRU) recency_front(f);
            end else begin
                f = 0;
                if (cur_policy == POL_FIFO) begin
                    f = fifo_next;
                    fifo_next = (f + 1) % NFR;
                end else if (cur_policy == POL_LRU && recency_len > 0) begin
                    f = recency[recency_len-1];
                    recency_len--;
                    recency_front(f);
                end
                r.evicted = 1'b1;
                r.evict_pid = PID_W'(own_pid[f]);
                r.evict_page = PAGE_W'(own_page[f]);
                vidx = own_pid[f] * NPG + own_page[f];
                r.writeback = pt_dirty[vidx];
                pt_dirty[vidx] = 1'b0;
                pt_valid[vidx] = 1'b0;
            end
            pt_valid[idx] = 1'b1;
            pt_dirty[idx] = wr;
            pt_frame[idx] = f;
            own_pid[f] = int'(pid);
            own_page[f] = pg;
        end
        r.phys_addr = PA_W'((f << 8) + int'(va[7:0]));
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        xlat_t got;
        xlat_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = xlat_t'(m_axis_tdata[25:0]);
            if (pending_xlat.size() == 0) begin
                $error("result with no access outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_xlat.pop_front();
                check_field("phys_addr", int'(want.phys_addr), int'(got.phys_addr));
                check_field("hit", int'(want.hit), int'(got.hit));
                check_field("range_error", int'(want.range_error), int'(got.range_error));
                check_field("evicted", int'(want.evicted), int'(got.evicted));
                check_field("evict_pid", int'(want.evict_pid), int'(got.evict_pid));
                check_field("evict_page", int'(want.evict_page), int'(got.evict_page));
                check_field("writeback", int'(want.writeback), int'(got.writeback));
            end
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: long stretches always ready, others stalling at random
    always @(negedge i_clk) begin
        int cyc;
        cyc = cyc + 1;
        if ((cyc / 300) % 2 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    int burst_left;

    task automatic send_access(logic [PID_W-1:0] pid, logic [VA_W-1:0] va, logic wr,
                               bit typed, xlat_t typed_res);
        xlat_t r;
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tdata = {5'b0, wr, va, pid};
        s_axis_tvalid = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = translate(pid, va, wr);
        pending_xlat.push_back(typed ? typed_res : r);
    endtask

    task automatic set_policy(t_policy p);
        @(negedge i_clk);
        s_axis_tvalid = 0;
        wait (pending_xlat.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_wdata = p;
        cur_policy = p;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic random_phase(int n);
        logic [PID_W-1:0] hot_pid [24];
        logic [7:0]       hot_page [24];
        logic [PID_W-1:0] pid;
        logic [7:0]       pg;
        for (int i = 0; i < 24; i++) begin
            hot_pid[i] = PID_W'($urandom_range(0, 3));
            hot_page[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < n; i++) begin
            int k;
            k = $urandom_range(0, 23);
            pid = hot_pid[k];
            pg = hot_page[k];
            // some cold accesses across the whole space
            if ($urandom_range(0, 99) < 15) begin
                pid = PID_W'($urandom_range(0, 3));
                pg = 8'($urandom_range(0, 255));
            end
            send_access(pid, {pg, 8'($urandom_range(0, 255))}, 1'($urandom_range(0, 1)),
                        0, '0);
        end
    endtask

    access_row_t dir_rows [$];

    initial begin
        access_row_t row;
        xlat_t z;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        cur_policy = POL_FIFO;
        frames_handed = 0;
        fifo_next = 0;
        recency_len = 0;
        z = '0;
        // first access after reset lands in frame 0, a miss
        row = '{2'd0, 16'h00FF, 1'b0, 1, '{0, 0, 0, 0, 0, 0, 12'h0FF}};
        dir_rows.push_back(row);
        row = '{2'd3, 16'hFFFF, 1'b1, 1, '{0, 0, 0, 0, 0, 0, 12'h1FF}};
        dir_rows.push_back(row);
        // hit on the first page
        row = '{2'd0, 16'h0000, 1'b1, 1, '{0, 0, 0, 0, 0, 1, 12'h000}};
        dir_rows.push_back(row);
        row = '{2'd3, 16'hFF00, 1'b0, 0, z};
        dir_rows.push_back(row);
        // fill the remaining frames, then force fifo evictions
        for (int i = 0; i < 20; i++) begin
            row = '{PID_W'(i), VA_W'((i + 1) << 8 | (i * 37 & 8'hFF)), 1'(i), 0, z};
            dir_rows.push_back(row);
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        foreach (dir_rows[i])
            send_access(dir_rows[i].pid, dir_rows[i].va, dir_rows[i].wr,
                        dir_rows[i].typed, dir_rows[i].res);
        random_phase(200);
        // lru with an empty recency list: frames were handed out under fifo
        set_policy(POL_LRU);
        random_phase(220);
        set_policy(POL_ZERO);
        random_phase(200);
        set_policy(POL_CLOCK);
        random_phase(200);
        set_policy(POL_LRU);
        random_phase(200);
        set_policy(POL_FIFO);
        random_phase(200);
        @(negedge i_clk);
        s_axis_tvalid = 0;
        wait (pending_xlat.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> filelist.f
sv/pmmu_pkg.sv
sv/pmmu_lru.sv
sv/paged_mmu_with_replacement_unit.sv
tb/sv/paged_mmu_with_replacement_unit_test.sv
